// ===== rtl/core/tdm_pkg.sv =====
// Package for the triangle map distortion block: shared widths and types.
// No dependencies; used by tdm_terms, tdm_search and the top level by scoped names.
package tdm_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int REF_W   = 31;
    localparam int Q_W     = 32;

    // Exact integer term widths
    localparam int K2_W    = 132;   // |e1 x e2|^2
    localparam int W2_W    = 124;   // (P V)^2
    localparam int NUM_W   = 133;   // numerator Nr
    localparam int FRAC_SHIFT = 28;
    localparam int LHS_W   = 2 * NUM_W + FRAC_SHIFT;   // Nr^2 * 2^28
    localparam int PVK_W   = W2_W + K2_W;              // (P V)^2 * K2
    localparam int ACC_W   = PVK_W + Q_W;              // PVK * q
    localparam int CMP_W   = PVK_W + 2 * Q_W + 2;      // trial term width

    // Control that travels with each item
    typedef struct packed {
        logic valid;
        logic degen;
    } ctl_t;

endpackage

// ===== rtl/core/tdm_mul.sv =====
// Pipelined unsigned multiplier built from 32x32 partial products.
// Registers products, row sums, pair sums and total on en; uses no package items.
module tdm_mul #(
    parameter int WA = 64,
    parameter int WB = 64
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [WA-1:0]      a,
    input  logic [WB-1:0]      b,
    output logic [WA+WB-1:0]   p
);
    localparam int LA = (WA + 31) / 32;
    localparam int LB = (WB + 31) / 32;
    localparam int RW = (LB + 1) * 32;
    localparam int NP = (LA + 1) / 2;
    localparam int PW = RW + 64;
    localparam int TW = (LA + LB) * 32;

    logic [LA*32-1:0] a_pad;
    logic [LB*32-1:0] b_pad;
    logic [63:0]      pp_reg   [LA][LB];
    logic [RW-1:0]    row_ev   [LA];
    logic [RW-1:0]    row_od   [LA];
    logic [RW-1:0]    row_reg  [LA];
    logic [PW-1:0]    pair_next[NP];
    logic [PW-1:0]    pair_reg [NP];
    logic [TW-1:0]    tot_next;
    logic [TW-1:0]    tot_reg;

    assign a_pad = (LA*32)'(a);
    assign b_pad = (LB*32)'(b);

    // Partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LA; i++) begin
                for (int j = 0; j < LB; j++) begin
                    pp_reg[i][j] <= {32'b0, a_pad[32*i +: 32]} * {32'b0, b_pad[32*j +: 32]};
                end
            end
        end
    end

    // Rows: even and odd products do not overlap, so one add per row
    always_comb begin
        for (int i = 0; i < LA; i++) begin
            row_ev[i] = '0;
            row_od[i] = '0;
            for (int j = 0; j < LB; j++) begin
                if (j % 2 == 0) begin
                    row_ev[i][32*j +: 64] = pp_reg[i][j];
                end else begin
                    row_od[i][32*j +: 64] = pp_reg[i][j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LA; i++) begin
                row_reg[i] <= row_ev[i] + row_od[i];
            end
        end
    end

    // Pairs of rows
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            pair_next[k] = PW'(row_reg[2*k]);
            if (2*k + 1 < LA) begin
                pair_next[k] = pair_next[k] + (PW'(row_reg[2*k+1]) << 32);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pair_reg <= pair_next;
        end
    end

    // Final sum of at most three pair terms
    always_comb begin
        tot_next = '0;
        for (int k = 0; k < NP; k++) begin
            tot_next = tot_next + (TW'(pair_reg[k]) << (64*k));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tot_reg <= tot_next;
        end
    end

    assign p = tot_reg[WA+WB-1:0];

endmodule

// ===== rtl/core/tdm_terms.sv =====
// Front end: edge vectors, cross and dot products, K2, (P V)^2, Nr and degen flag.
// Depends on tdm_pkg and tdm_mul. Nine enabled stages.
module tdm_terms (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [31:0]             pt [9],
    input  logic [30:0]                    ref_p,
    input  logic signed [31:0]             ref_u,
    input  logic [30:0]                    ref_v,
    output tdm_pkg::ctl_t                  ctl_out,
    output logic [tdm_pkg::NUM_W-1:0]      num,
    output logic [tdm_pkg::K2_W-1:0]       k2,
    output logic [tdm_pkg::W2_W-1:0]       w2
);
    // Stage valid bits, indexed by stage number
    logic [9:1] vld_reg;

    // Stage 1
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];
    logic [30:0]        p1_reg;
    logic signed [31:0] u1_reg;
    logic [30:0]        rv1_reg;

    // Stage 2
    logic signed [65:0] xa_reg [3];
    logic signed [65:0] xb_reg [3];
    logic signed [64:0] ue_reg [3];
    logic signed [64:0] pe_reg [3];
    logic signed [65:0] sq_e1  [3];
    logic [63:0]        l_reg  [3];
    logic [61:0]        vv2_reg;
    logic [61:0]        w2s_reg;

    // Stage 3
    logic signed [65:0] cd     [3];
    logic signed [64:0] dd     [3];
    logic signed [65:0] cn     [3];
    logic signed [64:0] dn     [3];
    logic [64:0]        cabs_reg [3];
    logic [63:0]        dabs_reg [3];
    logic [65:0]        len2_reg;
    logic [61:0]        vv3_reg;
    logic [61:0]        w3_reg;
    logic [7:3]         wz_reg;

    // Multiplier outputs (stage 7)
    logic [129:0]       csq [3];
    logic [127:0]       dsq [3];
    logic [127:0]       vlen;
    logic [123:0]       wsq;

    // Stages 8 and 9
    logic [131:0]       k2_8_reg;
    logic [129:0]       mix8_reg;
    logic [128:0]       t8_reg;
    logic [123:0]       w2_8_reg;
    logic               wz8_reg;
    logic [132:0]       num9_reg;
    logic [131:0]       k2_9_reg;
    logic [123:0]       w2_9_reg;
    logic               degen9_reg;

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[8:1], in_valid};
        end
    end

    // Stage 1: edge vectors
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= 33'(pt[3+i]) - 33'(pt[i]);
                e2_reg[i] <= 33'(pt[6+i]) - 33'(pt[i]);
            end
            p1_reg  <= ref_p;
            u1_reg  <= ref_u;
            rv1_reg <= ref_v;
        end
    end

    // Stage 2: single-width products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_e1[i] = 66'(e1_reg[i]) * 66'(e1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                xa_reg[i] <= 66'(e1_reg[(i+1)%3]) * 66'(e2_reg[(i+2)%3]);
                xb_reg[i] <= 66'(e1_reg[(i+2)%3]) * 66'(e2_reg[(i+1)%3]);
                ue_reg[i] <= 65'(u1_reg) * 65'(e1_reg[i]);
                pe_reg[i] <= 65'($signed({1'b0, p1_reg})) * 65'(e2_reg[i]);
                l_reg[i]  <= sq_e1[i][63:0];
            end
            vv2_reg <= {31'b0, rv1_reg} * {31'b0, rv1_reg};
            w2s_reg <= {31'b0, p1_reg} * {31'b0, rv1_reg};
        end
    end

    // Stage 3: differences, magnitudes and |e1|^2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cd[i] = xa_reg[i] - xb_reg[i];
            dd[i] = ue_reg[i] - pe_reg[i];
            cn[i] = -cd[i];
            dn[i] = -dd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                cabs_reg[i] <= cd[i][65] ? cn[i][64:0] : cd[i][64:0];
                dabs_reg[i] <= dd[i][64] ? dn[i][63:0] : dd[i][63:0];
            end
            len2_reg <= 66'(l_reg[0]) + 66'(l_reg[1]) + 66'(l_reg[2]);
            vv3_reg  <= vv2_reg;
            w3_reg   <= w2s_reg;
        end
    end

    // Zero P V flag, carried alongside the multipliers
    always_ff @(posedge aclk) begin
        if (en) begin
            wz_reg <= {wz_reg[6:3], (w2s_reg == '0)};
        end
    end

    // Stages 4 to 7: wide squares and products
    for (genvar i = 0; i < 3; i++) begin : g_sq
        tdm_mul #(.WA(65), .WB(65)) u_csq (
            .aclk(aclk), .en(en), .a(cabs_reg[i]), .b(cabs_reg[i]), .p(csq[i])
        );
        tdm_mul #(.WA(64), .WB(64)) u_dsq (
            .aclk(aclk), .en(en), .a(dabs_reg[i]), .b(dabs_reg[i]), .p(dsq[i])
        );
    end

    tdm_mul #(.WA(62), .WB(66)) u_vlen (
        .aclk(aclk), .en(en), .a(vv3_reg), .b(len2_reg), .p(vlen)
    );

    tdm_mul #(.WA(62), .WB(62)) u_wsq (
        .aclk(aclk), .en(en), .a(w3_reg), .b(w3_reg), .p(wsq)
    );

    // Stage 8: partial sums
    always_ff @(posedge aclk) begin
        if (en) begin
            k2_8_reg <= 132'(csq[0]) + 132'(csq[1]) + 132'(csq[2]);
            mix8_reg <= 130'(dsq[0]) + 130'(dsq[1]) + 130'(dsq[2]);
            t8_reg   <= 129'(vlen) + 129'(wsq);
            w2_8_reg <= wsq;
            wz8_reg  <= wz_reg[7];
        end
    end

    // Stage 9: numerator and degenerate flag
    always_ff @(posedge aclk) begin
        if (en) begin
            num9_reg   <= 133'(k2_8_reg) + 133'(mix8_reg) + 133'(t8_reg);
            k2_9_reg   <= k2_8_reg;
            w2_9_reg   <= w2_8_reg;
            degen9_reg <= (k2_8_reg == '0) | wz8_reg;
        end
    end

    assign ctl_out.valid = vld_reg[9];
    assign ctl_out.degen = degen9_reg;
    assign num = num9_reg;
    assign k2  = k2_9_reg;
    assign w2  = w2_9_reg;

endmodule

// ===== rtl/core/tdm_search.sv =====
// Result search: overflow test, then one quotient bit per stage by
// squared comparison with incremental update. Depends on tdm_pkg.
module tdm_search (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  tdm_pkg::ctl_t                  ctl_in,
    input  logic [tdm_pkg::LHS_W-1:0]      lhs,
    input  logic [tdm_pkg::PVK_W-1:0]      pvk,
    output logic                           res_valid,
    output logic [31:0]                    distortion,
    output logic                           invalid,
    output logic                           saturated
);
    localparam int RW = tdm_pkg::LHS_W;
    localparam int BW = tdm_pkg::ACC_W;
    localparam int KW = tdm_pkg::PVK_W;
    localparam int SW = tdm_pkg::CMP_W;
    localparam int NB = tdm_pkg::Q_W;

    // Remainder lhs - PVK q^2, accumulator PVK q, partial quotient
    tdm_pkg::ctl_t   ctl_reg [NB+1];
    logic            sat_reg [NB+1];
    logic [RW-1:0]   rm_reg  [NB+1];
    logic [BW-1:0]   b_reg   [NB+1];
    logic [KW-1:0]   pvk_reg [NB+1];
    logic [NB-1:0]   q_reg   [NB+1];

    // Entry stage: overflow when Nr^2 2^28 >= PVK 2^64
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (en) begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg[0] <= ({pvk, 64'b0} <= SW'(lhs));
            rm_reg[0]  <= lhs;
            b_reg[0]   <= '0;
            pvk_reg[0] <= pvk;
            q_reg[0]   <= '0;
        end
    end

    // One stage per quotient bit, most significant first
    for (genvar k = 0; k < NB; k++) begin : g_bit
        localparam int BIT = NB - 1 - k;
        logic [SW-1:0] trial;
        logic          take;

        // PVK ((q + 2^b)^2 - q^2) = (PVK q) 2^(b+1) + PVK 2^(2b)
        assign trial = (SW'(b_reg[k]) << (BIT + 1)) + (SW'(pvk_reg[k]) << (2 * BIT));
        assign take  = (SW'(rm_reg[k]) >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k+1] <= '0;
            end else if (en) begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sat_reg[k+1] <= sat_reg[k];
                pvk_reg[k+1] <= pvk_reg[k];
                if (take) begin
                    rm_reg[k+1] <= rm_reg[k] - trial[RW-1:0];
                    b_reg[k+1]  <= b_reg[k] + (BW'(pvk_reg[k]) << BIT);
                end else begin
                    rm_reg[k+1] <= rm_reg[k];
                    b_reg[k+1]  <= b_reg[k];
                end
                // this bit is still clear in q_reg[k]
                q_reg[k+1] <= q_reg[k] | (NB'(take) << BIT);
            end
        end
    end

    // Result: degenerate takes priority over overflow
    assign res_valid  = ctl_reg[NB].valid;
    assign invalid    = ctl_reg[NB].degen;
    assign saturated  = sat_reg[NB] & ~ctl_reg[NB].degen;
    assign distortion = (ctl_reg[NB].degen | sat_reg[NB]) ? '1 : q_reg[NB];

endmodule

// ===== rtl/core/triangle_map_distortion_top.sv =====
// Triangle map distortion: top level with wide squaring and output buffer.
// Depends on tdm_pkg, tdm_mul, tdm_terms and tdm_search.
//
// Takes one triangle item per clock while s_ready is high and returns one
// result per item, in order, as floor(65536 * D) of the blended MIPS / area
// distortion, with invalid set (and all ones out) for a degenerate triangle
// or zero reference size, and saturated set (all ones out) when the result
// does not fit 32 bits. Throughput is one item per cycle while s_ready is
// high. From acceptance to m_valid an item passes nine front-end stages for
// the exact integer terms, four for the 133-bit square and K2 product, one
// overflow stage and one stage per result bit for the 32-bit search, then
// the output register. The whole pipeline advances together; a two-entry
// output buffer keeps s_ready registered, so it drops only once the downstream
// side has held off for two results.
module triangle_map_distortion_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_corner0_x,
    input  logic signed [31:0] s_corner0_y,
    input  logic signed [31:0] s_corner0_z,
    input  logic signed [31:0] s_corner1_x,
    input  logic signed [31:0] s_corner1_y,
    input  logic signed [31:0] s_corner1_z,
    input  logic signed [31:0] s_corner2_x,
    input  logic signed [31:0] s_corner2_y,
    input  logic signed [31:0] s_corner2_z,
    input  logic [30:0]        s_ref_edge_len,
    input  logic signed [31:0] s_ref_third_u,
    input  logic [30:0]        s_ref_third_v,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_distortion,
    output logic               m_invalid,
    output logic               m_saturated
);
    logic                              en;
    logic signed [31:0]                pt [9];
    tdm_pkg::ctl_t                     t_ctl;
    logic [tdm_pkg::NUM_W-1:0]         t_num;
    logic [tdm_pkg::K2_W-1:0]          t_k2;
    logic [tdm_pkg::W2_W-1:0]          t_w2;
    logic [2*tdm_pkg::NUM_W-1:0]       num_sq;
    logic [tdm_pkg::PVK_W-1:0]         pvk;
    logic [tdm_pkg::LHS_W-1:0]         lhs;
    tdm_pkg::ctl_t                     ctl_d_reg [4];
    logic                              r_valid;
    logic [31:0]                       r_dist;
    logic                              r_inv;
    logic                              r_sat;
    logic                              out_free;
    logic                              m_valid_reg;
    logic [31:0]                       m_dist_reg;
    logic                              m_inv_reg;
    logic                              m_sat_reg;
    logic                              spare_valid_reg;
    logic [31:0]                       spare_dist_reg;
    logic                              spare_inv_reg;
    logic                              spare_sat_reg;

    // Pipeline advances whenever the spare output slot is free
    assign en      = ~spare_valid_reg;
    assign s_ready = en;

    assign pt[0] = s_corner0_x;
    assign pt[1] = s_corner0_y;
    assign pt[2] = s_corner0_z;
    assign pt[3] = s_corner1_x;
    assign pt[4] = s_corner1_y;
    assign pt[5] = s_corner1_z;
    assign pt[6] = s_corner2_x;
    assign pt[7] = s_corner2_y;
    assign pt[8] = s_corner2_z;

    tdm_terms u_terms (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .pt       (pt),
        .ref_p    (s_ref_edge_len),
        .ref_u    (s_ref_third_u),
        .ref_v    (s_ref_third_v),
        .ctl_out  (t_ctl),
        .num      (t_num),
        .k2       (t_k2),
        .w2       (t_w2)
    );

    // Nr^2 and (P V)^2 K2
    tdm_mul #(.WA(tdm_pkg::NUM_W), .WB(tdm_pkg::NUM_W)) u_num_sq (
        .aclk(aclk), .en(en), .a(t_num), .b(t_num), .p(num_sq)
    );

    tdm_mul #(.WA(tdm_pkg::W2_W), .WB(tdm_pkg::K2_W)) u_pvk (
        .aclk(aclk), .en(en), .a(t_w2), .b(t_k2), .p(pvk)
    );

    assign lhs = {num_sq, {tdm_pkg::FRAC_SHIFT{1'b0}}};

    // Control alongside the multipliers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                ctl_d_reg[i] <= '0;
            end
        end else if (en) begin
            ctl_d_reg[0] <= t_ctl;
            for (int i = 1; i < 4; i++) begin
                ctl_d_reg[i] <= ctl_d_reg[i-1];
            end
        end
    end

    tdm_search u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl_in     (ctl_d_reg[3]),
        .lhs        (lhs),
        .pvk        (pvk),
        .res_valid  (r_valid),
        .distortion (r_dist),
        .invalid    (r_inv),
        .saturated  (r_sat)
    );

    // Output register with spare slot
    assign out_free = ~m_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (spare_valid_reg) begin
                m_valid_reg     <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= r_valid;
            end
        end else if (en && r_valid) begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (spare_valid_reg) begin
                m_dist_reg <= spare_dist_reg;
                m_inv_reg  <= spare_inv_reg;
                m_sat_reg  <= spare_sat_reg;
            end else begin
                m_dist_reg <= r_dist;
                m_inv_reg  <= r_inv;
                m_sat_reg  <= r_sat;
            end
        end else if (en && r_valid) begin
            spare_dist_reg <= r_dist;
            spare_inv_reg  <= r_inv;
            spare_sat_reg  <= r_sat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_distortion = m_dist_reg;
    assign m_invalid    = m_inv_reg;
    assign m_saturated  = m_sat_reg;

    // Checks
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_invalid && m_saturated))
        else $error("invalid and saturated both set");

    a_flag_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_invalid || m_saturated)) |-> (m_distortion == 32'hFFFF_FFFF))
        else $error("flagged item without all-ones distortion");

    a_spare_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> m_valid_reg)
        else $error("spare slot filled while output register empty");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (spare_valid_reg && !m_ready) |=> (spare_valid_reg && $stable(spare_dist_reg)))
        else $error("spare item lost during stall");

endmodule
